@@ sv/nwsd_pkg.sv @@
package nwsd_pkg;

   // Table size and derived widths.
   localparam int MAX_SEGMENTS = 256;
   localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   // Request action codes.
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // Response status codes.
   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_ZERO = 2'd2;
   localparam logic [1:0] STS_FULL = 2'd3;

   // Number of two-bit steps in the square root.
   localparam int SQRT_STEPS = 32;

   // One stored segment.
   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [17:0] tangent_x;
      logic signed [17:0] tangent_y;
      logic [29:0]        half_length;
   } seg_entry_type;

   localparam int ENTRY_W = $bits(seg_entry_type);

endpackage

@@ sv/nwsd_ram.sv @@
module nwsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/nearest_wall_segment_distance.sv @@
// Channel   Direction  Handshake          Payload
// req       in         req_valid/req_stall action, center, normal, length, query
// rsp       out        rsp_valid/rsp_stall min_distance, status
//
// Clear and load requests finish in the cycle they are accepted.
// A query streams the segment memory through the distance pipeline, then runs the
// square root unit and loads the response register once that register is free.
// Reset is synchronous and empties the table; memory contents stay undefined.
// A request is taken only while no query is running and the response register is free.
module nearest_wall_segment_distance (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [17:0] req_normal_x,
   input  logic signed [17:0] req_normal_y,
   input  logic [30:0]        req_seg_length,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [30:0]        rsp_min_distance,
   output logic [1:0]         rsp_status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_SQRT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [nwsd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [nwsd_pkg::CNT_W-1:0] issue_ff, issue_in;
   logic [6:0] vld_ff, vld_in;
   logic signed [31:0] qx_ff, qy_ff;
   logic [63:0] best_ff, best_in;
   logic [63:0] rad_ff, rad_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [30:0] rsp_dist_ff, rsp_dist_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic accept, out_free, issue;
   logic wr_en;
   nwsd_pkg::seg_entry_type wr_entry, rd_entry;
   logic [nwsd_pkg::ENTRY_W-1:0] rd_bits;

   // Pipeline stage registers.
   logic signed [32:0] s1_dx_ff, s1_dy_ff;
   logic signed [17:0] s1_tx_ff, s1_ty_ff, s2_tx_ff, s2_ty_ff, s3_tx_ff, s3_ty_ff;
   logic [29:0] s1_h_ff, s2_h_ff;
   logic signed [31:0] s1_cx_ff, s1_cy_ff, s2_cx_ff, s2_cy_ff;
   logic signed [31:0] s3_cx_ff, s3_cy_ff, s4_cx_ff, s4_cy_ff;
   logic signed [50:0] s2_px_ff, s2_py_ff;
   logic signed [30:0] s3_along_ff;
   logic signed [48:0] s4_ox_ff, s4_oy_ff;
   logic [31:0] s5_mx_ff, s5_my_ff;
   logic [63:0] s6_sx_ff, s6_sy_ff;

   logic signed [51:0] s3_sum;
   logic signed [35:0] s3_al, s3_hx;
   logic signed [30:0] s3_along;
   logic [31:0] s5_mx, s5_my;
   logic [63:0] s7_d;
   logic [35:0] sq_rem, sq_trial, sq_diff;

   // Magnitude of one error component, clamped to 2^31.
   function automatic logic [31:0] err_mag(input logic signed [31:0] q,
                                           input logic signed [31:0] c,
                                           input logic signed [48:0] o);
      logic signed [32:0] off;
      logic signed [33:0] p;
      logic signed [34:0] e;
      logic [34:0] a;
      off = o[48:16];
      p = {{2{c[31]}}, c} + {off[32], off};
      e = {{3{q[31]}}, q} - {p[33], p};
      a = e[34] ? 35'(-e) : 35'(e);
      if (a > 35'h080000000) begin
         err_mag = 32'h80000000;
      end else begin
         err_mag = a[31:0];
      end
   endfunction

   assign out_free = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept = req_valid && !req_stall;
   assign issue = (state_ff == ST_SCAN) && (issue_ff < count_ff);

   // Segment store write on an accepted load into a table with room.
   assign wr_en = accept && (req_action == nwsd_pkg::ACT_LOAD) &&
                  (count_ff < nwsd_pkg::CNT_W'(nwsd_pkg::MAX_SEGMENTS));
   always_comb begin
      wr_entry.center_x = req_center_x;
      wr_entry.center_y = req_center_y;
      wr_entry.tangent_x = (req_normal_y == 18'sh20000) ? 18'sh1FFFF : 18'(-req_normal_y);
      wr_entry.tangent_y = req_normal_x;
      wr_entry.half_length = req_seg_length[30:1];
   end

   nwsd_ram #(
      .WIDTH(nwsd_pkg::ENTRY_W),
      .DEPTH(nwsd_pkg::MAX_SEGMENTS)
   ) u_seg_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[nwsd_pkg::ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (issue_ff[nwsd_pkg::ADDR_W-1:0]),
      .rd_data (rd_bits)
   );
   assign rd_entry = nwsd_pkg::seg_entry_type'(rd_bits);

   // Projection clamp, error magnitudes and squared-distance sum.
   always_comb begin
      s3_sum = {s2_px_ff[50], s2_px_ff} + {s2_py_ff[50], s2_py_ff};
      s3_al = s3_sum[51:16];
      s3_hx = $signed({6'd0, s2_h_ff});
      if (s3_al > s3_hx) begin
         s3_along = s3_hx[30:0];
      end else if (s3_al < -s3_hx) begin
         s3_along = 31'(-s3_hx);
      end else begin
         s3_along = s3_al[30:0];
      end
      s5_mx = err_mag(qx_ff, s4_cx_ff, s4_ox_ff);
      s5_my = err_mag(qy_ff, s4_cy_ff, s4_oy_ff);
      s7_d = s6_sx_ff + s6_sy_ff;
   end

   // Distance pipeline datapath.
   always_ff @(posedge clock) begin
      s1_dx_ff <= {qx_ff[31], qx_ff} - {rd_entry.center_x[31], rd_entry.center_x};
      s1_dy_ff <= {qy_ff[31], qy_ff} - {rd_entry.center_y[31], rd_entry.center_y};
      s1_tx_ff <= rd_entry.tangent_x;
      s1_ty_ff <= rd_entry.tangent_y;
      s1_h_ff <= rd_entry.half_length;
      s1_cx_ff <= rd_entry.center_x;
      s1_cy_ff <= rd_entry.center_y;
      s2_px_ff <= s1_dx_ff * s1_tx_ff;
      s2_py_ff <= s1_dy_ff * s1_ty_ff;
      s2_tx_ff <= s1_tx_ff;
      s2_ty_ff <= s1_ty_ff;
      s2_h_ff <= s1_h_ff;
      s2_cx_ff <= s1_cx_ff;
      s2_cy_ff <= s1_cy_ff;
      s3_along_ff <= s3_along;
      s3_tx_ff <= s2_tx_ff;
      s3_ty_ff <= s2_ty_ff;
      s3_cx_ff <= s2_cx_ff;
      s3_cy_ff <= s2_cy_ff;
      s4_ox_ff <= s3_tx_ff * s3_along_ff;
      s4_oy_ff <= s3_ty_ff * s3_along_ff;
      s4_cx_ff <= s3_cx_ff;
      s4_cy_ff <= s3_cy_ff;
      s5_mx_ff <= s5_mx;
      s5_my_ff <= s5_my;
      s6_sx_ff <= s5_mx_ff * s5_mx_ff;
      s6_sy_ff <= s5_my_ff * s5_my_ff;
      if (accept) begin
         qx_ff <= req_query_x;
         qy_ff <= req_query_y;
      end
   end

   // Square root step: two radicand bits per cycle.
   always_comb begin
      sq_rem = {rem_ff, rad_ff[63:62]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_diff = sq_rem - sq_trial;
   end

   // Control sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      issue_in = issue_ff;
      vld_in = {vld_ff[5:0], issue};
      best_in = best_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dist_in = rsp_dist_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in = '0;
               rsp_status_in = nwsd_pkg::STS_OK;
               unique case (req_action)
                  nwsd_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  nwsd_pkg::ACT_LOAD: begin
                     if (wr_en) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        rsp_status_in = nwsd_pkg::STS_FULL;
                     end
                  end
                  nwsd_pkg::ACT_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_status_in = nwsd_pkg::STS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        issue_in = '0;
                        best_in = '1;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + 1'b1;
            end
            if (vld_ff[6] && (s7_d < best_ff)) begin
               best_in = s7_d;
            end
            if (!issue && (vld_ff == '0)) begin
               rad_in = best_ff;
               rem_in = '0;
               root_in = '0;
               step_in = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rad_in = {rad_ff[61:0], 2'b00};
            if (!sq_diff[35]) begin
               rem_in = sq_diff[33:0];
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in = sq_rem[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 5'(nwsd_pkg::SQRT_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in = root_ff[31] ? 31'h7FFFFFFF : root_ff[30:0];
               rsp_status_in = (root_ff == '0) ? nwsd_pkg::STS_ZERO : nwsd_pkg::STS_OK;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         issue_ff <= '0;
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         issue_ff <= issue_in;
         vld_ff <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      best_ff <= best_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_min_distance = rsp_dist_ff;
   assign rsp_status = rsp_status_ff;

endmodule

@@ dv/nwsd_checker.sv @@
module nwsd_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [17:0] req_normal_x,
   input  logic signed [17:0] req_normal_y,
   input  logic [30:0]        req_seg_length,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [30:0]        rsp_min_distance,
   input  logic [1:0]         rsp_status,
   output int                 fail_count,
   output int                 pending,
   output int                 checked
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned DIST_MAX = 64'h7FFF_FFFF;
   localparam longint ERR_CLAMP = 64'sh8000_0000;

   typedef struct {
      logic [30:0] distance;
      logic [1:0]  status;
   } answer_type;

   // Shadow copy of the segment table.
   longint wall_cx [nwsd_pkg::MAX_SEGMENTS];
   longint wall_cy [nwsd_pkg::MAX_SEGMENTS];
   longint wall_tx [nwsd_pkg::MAX_SEGMENTS];
   longint wall_ty [nwsd_pkg::MAX_SEGMENTS];
   longint wall_half [nwsd_pkg::MAX_SEGMENTS];
   int     wall_count;

   answer_type expected_answers[$];

   initial begin
      fail_count = 0;
      checked = 0;
      wall_count = 0;
   end

   assign pending = expected_answers.size();

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   function automatic longint clamp_value(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned root;
      longint unsigned step;
      root = 0;
      step = 64'd1 << 62;
      while (step > v) step >>= 2;
      while (step != 0) begin
         if (v >= root + step) begin
            v -= root + step;
            root = (root >> 1) + step;
         end else begin
            root >>= 1;
         end
         step >>= 2;
      end
      return root;
   endfunction

   // Squared distance from the point to segment i, projection clamped to its ends.
   function automatic longint unsigned wall_distance_sq(input int i, input longint qx,
                                                        input longint qy);
      longint along;
      longint ex;
      longint ey;
      along = ((qx - wall_cx[i]) * wall_tx[i] + (qy - wall_cy[i]) * wall_ty[i]) >>> 16;
      along = clamp_value(along, -wall_half[i], wall_half[i]);
      ex = qx - (wall_cx[i] + ((wall_tx[i] * along) >>> 16));
      ey = qy - (wall_cy[i] + ((wall_ty[i] * along) >>> 16));
      ex = clamp_value(ex, -ERR_CLAMP, ERR_CLAMP);
      ey = clamp_value(ey, -ERR_CLAMP, ERR_CLAMP);
      return longint'(ex * ex) + longint'(ey * ey);
   endfunction

   // Apply one accepted request to the shadow table and work out its response.
   function automatic answer_type apply_request();
      answer_type ans;
      longint unsigned best;
      longint unsigned d;
      ans.distance = '0;
      ans.status = nwsd_pkg::STS_OK;
      case (req_action)
         nwsd_pkg::ACT_CLEAR: begin
            wall_count = 0;
         end
         nwsd_pkg::ACT_LOAD: begin
            if (wall_count >= nwsd_pkg::MAX_SEGMENTS) begin
               ans.status = nwsd_pkg::STS_FULL;
            end else begin
               wall_cx[wall_count] = req_center_x;
               wall_cy[wall_count] = req_center_y;
               wall_tx[wall_count] = clamp_value(-longint'(req_normal_y), -131072, 131071);
               wall_ty[wall_count] = req_normal_x;
               wall_half[wall_count] = req_seg_length >> 1;
               wall_count++;
            end
         end
         nwsd_pkg::ACT_QUERY: begin
            if (wall_count == 0) begin
               ans.status = nwsd_pkg::STS_EMPTY;
            end else begin
               best = wall_distance_sq(0, req_query_x, req_query_y);
               for (int i = 1; i < wall_count; i++) begin
                  d = wall_distance_sq(i, req_query_x, req_query_y);
                  if (d < best) best = d;
               end
               d = floor_sqrt(best);
               if (d > DIST_MAX) d = DIST_MAX;
               ans.distance = d[30:0];
               if (d == 0) ans.status = nwsd_pkg::STS_ZERO;
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   // Predict on every accepted request.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_answers.insert(expected_answers.size(), apply_request());
      end
   end

   // Compare every accepted response with the oldest prediction.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_status, -1);
         end else begin
            want = expected_answers.pop_front();
            checked++;
            if (rsp_min_distance !== want.distance)
               report_mismatch("min_distance", rsp_min_distance, want.distance);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

endmodule

@@ dv/nearest_wall_segment_distance_tb.sv @@
module nearest_wall_segment_distance_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 950;

   // Action code that the block leaves unused.
   localparam logic [1:0] ACT_SPARE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = nwsd_pkg::ACT_CLEAR;
   logic signed [31:0] req_center_x = '0;
   logic signed [31:0] req_center_y = '0;
   logic signed [17:0] req_normal_x = '0;
   logic signed [17:0] req_normal_y = '0;
   logic [30:0]        req_seg_length = '0;
   logic signed [31:0] req_query_x = '0;
   logic signed [31:0] req_query_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [30:0]        rsp_min_distance;
   logic [1:0]         rsp_status;

   int fail_count;
   int pending;
   int checked;
   int send_idle_pct = 34;
   int rsp_idle_pct = 46;
   int sent = 0;
   int loads_sent = 0;
   int queries_sent = 0;
   int table_fill = 0;
   logic signed [31:0] last_cx = '0;
   logic signed [31:0] last_cy = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   nearest_wall_segment_distance u_top (.*);

   nwsd_checker u_checker (.*);

   // The response side stalls at random.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // Drive one request, with an optional random gap first, and wait for acceptance.
   task automatic send_request(input logic [1:0] action, input logic [31:0] cx,
                               input logic [31:0] cy, input logic [17:0] nx,
                               input logic [17:0] ny, input logic [30:0] len,
                               input logic [31:0] qx, input logic [31:0] qy);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_center_x <= cx;
      req_center_y <= cy;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_seg_length <= len;
      req_query_x <= qx;
      req_query_y <= qy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      if (action == nwsd_pkg::ACT_CLEAR) table_fill = 0;
      if (action == nwsd_pkg::ACT_LOAD) begin
         loads_sent++;
         if (table_fill < nwsd_pkg::MAX_SEGMENTS) begin
            table_fill++;
            last_cx = cx;
            last_cy = cy;
         end
      end
      if (action == nwsd_pkg::ACT_QUERY) queries_sent++;
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3, 4: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [17:0] pick_normal();
      case ($urandom_range(7))
         0: return 18'sd65536;
         1: return -18'sd65536;
         2: return '0;
         3: return 18'h20000;
         4: return 18'sd46341;
         5: return -18'sd46341;
         default: return 18'($urandom);
      endcase
   endfunction

   function automatic logic [30:0] pick_length();
      case ($urandom_range(5))
         0: return '0;
         1: return 31'h7FFF_FFFF;
         2, 3: return 31'($urandom_range(0, 32'h00FF_FFFF));
         default: return 31'($urandom);
      endcase
   endfunction

   task automatic random_load();
      send_request(nwsd_pkg::ACT_LOAD, pick_coord(), pick_coord(), pick_normal(),
                   pick_normal(), pick_length(), $urandom, $urandom);
   endtask

   task automatic random_query();
      if (table_fill > 0 && $urandom_range(9) == 0)
         send_request(nwsd_pkg::ACT_QUERY, $urandom, $urandom, 18'($urandom),
                      18'($urandom), 31'($urandom), last_cx, last_cy);
      else
         send_request(nwsd_pkg::ACT_QUERY, $urandom, $urandom, 18'($urandom),
                      18'($urandom), 31'($urandom), pick_coord(), pick_coord());
   endtask

   initial begin
      int r;
      bit filled;
      filled = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty table, unused code, exact distances, extremes.
      send_request(nwsd_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0);
      send_request(nwsd_pkg::ACT_QUERY, '0, '0, '0, '0, '0, '0, '0);
      send_request(ACT_SPARE, '1, '1, '1, '1, '1, '1, '1);
      send_request(nwsd_pkg::ACT_LOAD, '0, '0, '0, 18'sd65536, 31'd131072, '0, '0);
      send_request(nwsd_pkg::ACT_QUERY, '0, '0, '0, '0, '0, '0, '0);
      send_request(nwsd_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 32'sd327680, '0);
      send_request(nwsd_pkg::ACT_QUERY, '0, '0, '0, '0, '0, '0, 32'sd196608);
      send_request(nwsd_pkg::ACT_LOAD, 32'h8000_0000, 32'h8000_0000, 18'h20000, 18'h20000,
                   31'h7FFF_FFFF, '0, '0);
      send_request(nwsd_pkg::ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0, '0, '0);
      send_request(nwsd_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(nwsd_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(nwsd_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0);
      send_request(nwsd_pkg::ACT_LOAD, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0, '0);
      send_request(nwsd_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(nwsd_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0);
      send_request(nwsd_pkg::ACT_QUERY, '0, '0, '0, '0, '0, 32'h7FFF_FFFF, '0);

      // Random part in three idling phases; one pass fills the table past full.
      while (sent < RANDOM_REQUESTS) begin
         if (sent > 2 * RANDOM_REQUESTS / 3) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (sent > RANDOM_REQUESTS / 3) begin
            send_idle_pct = 46;
            rsp_idle_pct = 34;
         end
         r = $urandom_range(99);
         if (!filled && sent > RANDOM_REQUESTS / 2) begin
            filled = 1;
            while (table_fill < nwsd_pkg::MAX_SEGMENTS) random_load();
            repeat (3) random_load();
            repeat (4) random_query();
            send_request(nwsd_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, '0, '0);
         end else if (r < 8) begin
            send_request(nwsd_pkg::ACT_CLEAR, $urandom, $urandom, 18'($urandom),
                         18'($urandom), 31'($urandom), $urandom, $urandom);
         end else if (r < 11) begin
            send_request(ACT_SPARE, $urandom, $urandom, 18'($urandom), 18'($urandom),
                         31'($urandom), $urandom, $urandom);
         end else if (r < 50) begin
            random_load();
         end else begin
            random_query();
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d requests: %0d loads, %0d queries, the rest clears and unused codes.",
               sent, loads_sent, queries_sent);
      $display("Checked %0d responses, including one pass over a full table.", checked);
      if (fail_count == 0 && pending == 0) begin
         $display("nearest_wall_segment_distance_tb passed");
      end else begin
         $display("nearest_wall_segment_distance_tb failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #20ms;
      $display("Timeout with %0d responses outstanding.", pending);
      $display("nearest_wall_segment_distance_tb failed");
      $finish;
   end

endmodule
